>>> hdl/eats_pkg.sv
// Shared types and constants for the encoder accelerated time selector.
package eats_pkg;

	localparam int BaseW    = 12;
	localparam int TotalW   = 24;
	localparam int ThrW     = 16;
	localparam int MultW    = 7;
	localparam int TimeoutW = 23;
	localparam int StepW    = 8;
	localparam int TimeW    = 32;
	localparam int AppliedW = 25;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;
	localparam int InDataW  = 40;
	localparam int OutDataW = 88;

	localparam logic [CfgIdxW-1:0] RegBaseStep  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegMaxTotal  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegMediumThr = 3'd2;
	localparam logic [CfgIdxW-1:0] RegFastThr   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMediumMul = 3'd4;
	localparam logic [CfgIdxW-1:0] RegFastMul   = 3'd5;
	localparam logic [CfgIdxW-1:0] RegTimeout   = 3'd6;

	localparam logic [BaseW-1:0]    BaseStepRst  = 12'd60;
	localparam logic [TotalW-1:0]   MaxTotalRst  = 24'd86400;
	localparam logic [ThrW-1:0]     MediumThrRst = 16'd10;
	localparam logic [ThrW-1:0]     FastThrRst   = 16'd30;
	localparam logic [MultW-1:0]    MediumMulRst = 7'd5;
	localparam logic [MultW-1:0]    FastMulRst   = 7'd15;
	localparam logic [TimeoutW-1:0] TimeoutRst   = 23'd1500;
	localparam logic [TotalW-1:0]   TotalRst     = 24'd60;

	localparam logic [27:0] UsPerSecond = 28'd1000000;
	localparam logic [32:0] UsPerMs     = 33'd1000;

	localparam logic FuncSample = 1'b0;
	localparam logic FuncTick   = 1'b1;

	typedef struct packed {
		logic [BaseW-1:0]    base_step;
		logic [TotalW-1:0]   max_total;
		logic [ThrW-1:0]     medium_thr;
		logic [ThrW-1:0]     fast_thr;
		logic [MultW-1:0]    medium_mul;
		logic [MultW-1:0]    fast_mul;
		logic [TimeoutW-1:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic do_lhs;
		logic do_fast;
		logic do_med;
		logic do_sel;
		logic do_scale;
		logic do_apply;
		logic do_commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit;
	} stat_t;

endpackage

>>> hdl/eats_cfg.sv
// Configuration register file written through the plain write port.
module eats_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [eats_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [eats_pkg::CfgDataW-1:0]  cfg_data,
	output eats_pkg::cfg_t                 cfg
);

	eats_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_step  <= eats_pkg::BaseStepRst;
			cfg_q.max_total  <= eats_pkg::MaxTotalRst;
			cfg_q.medium_thr <= eats_pkg::MediumThrRst;
			cfg_q.fast_thr   <= eats_pkg::FastThrRst;
			cfg_q.medium_mul <= eats_pkg::MediumMulRst;
			cfg_q.fast_mul   <= eats_pkg::FastMulRst;
			cfg_q.timeout_ms <= eats_pkg::TimeoutRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eats_pkg::RegBaseStep:  cfg_q.base_step  <= cfg_data[eats_pkg::BaseW-1:0];
				eats_pkg::RegMaxTotal:  cfg_q.max_total  <= cfg_data[eats_pkg::TotalW-1:0];
				eats_pkg::RegMediumThr: cfg_q.medium_thr <= cfg_data[eats_pkg::ThrW-1:0];
				eats_pkg::RegFastThr:   cfg_q.fast_thr   <= cfg_data[eats_pkg::ThrW-1:0];
				eats_pkg::RegMediumMul: cfg_q.medium_mul <= cfg_data[eats_pkg::MultW-1:0];
				eats_pkg::RegFastMul:   cfg_q.fast_mul   <= cfg_data[eats_pkg::MultW-1:0];
				eats_pkg::RegTimeout:   cfg_q.timeout_ms <= cfg_data[eats_pkg::TimeoutW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/eats_dp.sv
// Datapath: speed test products, step scaling, clamping, state and output register.
module eats_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  eats_pkg::cfg_t                 cfg,
	input  eats_pkg::cmd_t                 cmd,
	input  logic                           in_func,
	input  logic [eats_pkg::InDataW-1:0]   in_data,
	output eats_pkg::stat_t                stat,
	output logic                           out_func,
	output logic [eats_pkg::OutDataW-1:0]  out_data
);

	logic                                func_q;
	logic signed [eats_pkg::StepW-1:0]   step_q;
	logic [eats_pkg::TimeW-1:0]          time_q;
	logic [eats_pkg::TimeW-1:0]          dt_q;
	logic [27:0]                         lhs_q;
	logic [32:0]                         lim_q;
	logic [eats_pkg::TimeW-1:0]          elapsed_q;
	logic [47:0]                         rhs_q;
	logic [19:0]                         basemag_q;
	logic                                fast_ok_q;
	logic [eats_pkg::MultW-1:0]          mult_q;
	logic [26:0]                         delta_q;
	logic [eats_pkg::TotalW-1:0]         next_q;
	logic [eats_pkg::AppliedW-1:0]       applied_q;
	logic                                emit_q;

	logic [eats_pkg::TotalW-1:0]         acc_q;
	logic [eats_pkg::TimeW-1:0]          prev_time_q;
	logic                                prev_valid_q;
	logic [eats_pkg::TimeW-1:0]          last_act_q;
	logic                                act_valid_q;
	logic                                commit_done_q;

	logic                                out_func_q;
	logic [eats_pkg::OutDataW-1:0]       out_data_q;

	logic [eats_pkg::StepW-1:0]          mag;
	logic                                med_ok;
	logic [27:0]                         sum;
	logic [26:0]                         low;
	logic [27:0]                         clamp_lo;
	logic [eats_pkg::TotalW-1:0]         next;
	logic                                step_nz;

	assign mag = step_q[eats_pkg::StepW-1] ? eats_pkg::StepW'(-step_q) : eats_pkg::StepW'(step_q);
	assign step_nz = (step_q != '0);
	assign med_ok = (dt_q == '0) ? (cfg.medium_thr == '0) : ({20'b0, lhs_q} >= rhs_q);

	always_comb begin
		sum = 28'(acc_q) + 28'(delta_q);
		low = ({3'b0, acc_q} >= delta_q) ? (27'(acc_q) - delta_q) : 27'd0;
		clamp_lo = step_q[eats_pkg::StepW-1] ? 28'(low) : sum;
		next = (clamp_lo > 28'(cfg.max_total)) ? cfg.max_total : clamp_lo[eats_pkg::TotalW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			step_q <= in_data[eats_pkg::StepW-1:0];
			time_q <= in_data[eats_pkg::InDataW-1:eats_pkg::StepW];
			dt_q   <= prev_valid_q ?
				(in_data[eats_pkg::InDataW-1:eats_pkg::StepW] - prev_time_q) : '0;
		end
		if (cmd.do_lhs) begin
			lhs_q     <= 28'(mag) * eats_pkg::UsPerSecond;
			lim_q     <= 33'(cfg.timeout_ms) * eats_pkg::UsPerMs;
			elapsed_q <= time_q - last_act_q;
		end
		if (cmd.do_fast) begin
			rhs_q     <= 48'(cfg.fast_thr) * 48'(dt_q);
			basemag_q <= 20'(mag) * 20'(cfg.base_step);
		end
		if (cmd.do_med) begin
			fast_ok_q <= (dt_q == '0) ? (cfg.fast_thr == '0) : ({20'b0, lhs_q} >= rhs_q);
			rhs_q     <= 48'(cfg.medium_thr) * 48'(dt_q);
		end
		if (cmd.do_sel) begin
			mult_q <= fast_ok_q ? cfg.fast_mul : (med_ok ? cfg.medium_mul : 7'd1);
		end
		if (cmd.do_scale) begin
			delta_q <= 27'(basemag_q) * 27'(mult_q);
		end
		if (cmd.do_apply) begin
			next_q    <= next;
			applied_q <= eats_pkg::AppliedW'(next) - eats_pkg::AppliedW'(acc_q);
			emit_q    <= (func_q == eats_pkg::FuncTick) ?
				(!commit_done_q && act_valid_q && ({1'b0, elapsed_q} >= lim_q)) :
				(step_nz && (next != acc_q));
		end
		if (cmd.load_out) begin
			out_func_q <= func_q;
			if (func_q == eats_pkg::FuncTick) begin
				out_data_q <= {7'd0, time_q, 25'd0, acc_q};
			end else begin
				out_data_q <= {mult_q, time_q, applied_q, next_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= eats_pkg::TotalRst;
			prev_time_q   <= '0;
			prev_valid_q  <= 1'b0;
			last_act_q    <= '0;
			act_valid_q   <= 1'b0;
			commit_done_q <= 1'b0;
		end else if (cmd.do_commit) begin
			if (func_q == eats_pkg::FuncTick) begin
				if (emit_q) begin
					commit_done_q <= 1'b1;
				end
			end else begin
				commit_done_q <= 1'b0;
				last_act_q    <= time_q;
				act_valid_q   <= 1'b1;
				if (step_nz) begin
					prev_time_q  <= time_q;
					prev_valid_q <= 1'b1;
				end
				if (emit_q) begin
					acc_q <= next_q;
				end
			end
		end
	end

	assign stat.emit = emit_q;
	assign out_func  = out_func_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/eats_ctrl.sv
// Controller: sequences one request through the datapath and owns the output handshake.
module eats_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  eats_pkg::stat_t stat,
	output eats_pkg::cmd_t  cmd
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StLhs   = 3'd1;
	localparam logic [2:0] StFast  = 3'd2;
	localparam logic [2:0] StMed   = 3'd3;
	localparam logic [2:0] StSel   = 3'd4;
	localparam logic [2:0] StScale = 3'd5;
	localparam logic [2:0] StApply = 3'd6;
	localparam logic [2:0] StFin   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == StIdle);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = StLhs;
				end
			end
			StLhs: begin
				cmd.do_lhs = 1'b1;
				state_d = StFast;
			end
			StFast: begin
				cmd.do_fast = 1'b1;
				state_d = StMed;
			end
			StMed: begin
				cmd.do_med = 1'b1;
				state_d = StSel;
			end
			StSel: begin
				cmd.do_sel = 1'b1;
				state_d = StScale;
			end
			StScale: begin
				cmd.do_scale = 1'b1;
				state_d = StApply;
			end
			StApply: begin
				cmd.do_apply = 1'b1;
				state_d = StFin;
			end
			StFin: begin
				if (!stat.emit) begin
					cmd.do_commit = 1'b1;
					state_d = StIdle;
				end else if (out_free) begin
					cmd.do_commit = 1'b1;
					cmd.load_out = 1'b1;
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/encoder_accelerated_time_selector_core.sv
// Top level of the encoder accelerated time selector.
// Each request is handled alone. It is accepted in the idle state, and then the controller
// runs seven steps with s_axis_tready low: two steps for the speed test and timeout
// products, one for the last speed comparison, one to choose the multiplier, one to scale
// the step, one to clamp the total and one to update the state and load the result. A new
// request is therefore accepted only after the last step of the previous one has completed.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; the last step holds only if a new result is due and
// the output register is still full. Sample requests that move the total give
// a delta event, ticks give one commit event after the inactivity timeout.
module encoder_accelerated_time_selector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Fields from bit 0: step_count[7:0], time_us[39:8].
	input  logic [eats_pkg::InDataW-1:0]   s_axis_tdata,
	// Fields from bit 0: func[0].
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Fields from bit 0: total[23:0], applied_seconds[48:24],
	// event_time_us[80:49], used_multiplier[87:81].
	output logic [eats_pkg::OutDataW-1:0]  m_axis_tdata,
	// Fields from bit 0: event_kind[0].
	output logic                           m_axis_tuser,
	input  logic                           cfg_we,
	input  logic [eats_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [eats_pkg::CfgDataW-1:0]  cfg_data
);

	eats_pkg::cfg_t  cfg;
	eats_pkg::cmd_t  cmd;
	eats_pkg::stat_t stat;

	eats_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eats_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	eats_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_func  (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.stat     (stat),
		.out_func (m_axis_tuser),
		.out_data (m_axis_tdata)
	);

endmodule
